// ----- sv/iir_df1_pkg.sv -----
`timescale 1ns / 1ps
// iir_df1_pkg: shared types and constants for the direct form I IIR filter.
// No dependencies.
package iir_df1_pkg;

  localparam int COEF_W         = 18;
  localparam int COEF_FRAC_BITS = 14;
  localparam int USED_W         = 2;
  localparam int APB_ADDR_W     = 5;
  localparam int APB_DATA_W     = 32;
  localparam int REG_IDX_W      = 3;

  localparam logic signed [COEF_W-1:0] COEF_B0_RESET = COEF_W'(16384);
  localparam logic [USED_W-1:0]        USED_RESET    = USED_W'(1);
  localparam logic [USED_W-1:0]        USED_MAX      = USED_W'(3);
  localparam logic [USED_W-1:0]        WARMUP_RESET  = USED_W'(1);
  localparam logic [USED_W-1:0]        WARMUP_MAX    = USED_W'(3);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_B2 = 3'd2,
    REG_COEF_A1 = 3'd3,
    REG_COEF_A2 = 3'd4,
    REG_USED_B  = 3'd5,
    REG_USED_A  = 3'd6
  } cfg_reg_e;

endpackage

// ----- sv/iir_direct_form_one_filter.sv -----
`timescale 1ns / 1ps
// iir_direct_form_one_filter: direct form I biquad IIR, one sample per cycle
// unless the output stalls, APB coefficient registers. Depends on iir_df1_pkg.
//
//   channel   dir  fields (low bit up)
//   s_axis    in   tdata: sample
//   m_axis    out  tdata: filtered; tuser: clipped
//   apb       in   registers coef_b0..coef_a2, used_b, used_a at 4*i
//
// Path from input transaction to result: an input register, then the
// multiply/accumulate, rounding and saturation into the result register.
// One sample per cycle sustained while the output is not stalled; the feedback
// path (five multipliers and the sum into the output history) has no register.
// Reset clears histories, sets the warm-up count to 1 and restores default coefficients.
// A stalled output holds the input register; a new sample is taken whenever
// the input register empties or moves on in the same cycle.
module iir_direct_form_one_filter #(
  parameter int SAMPLE_BITS = 16,
  localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [DATA_W-1:0]                     s_axis_tdata,   // sample
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [DATA_W-1:0]                     m_axis_tdata,   // filtered
  output logic [0:0]                            m_axis_tuser,   // clipped
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [iir_df1_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [iir_df1_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [iir_df1_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                  pready
);

  localparam int COEF_W = iir_df1_pkg::COEF_W;
  localparam int FRAC   = iir_df1_pkg::COEF_FRAC_BITS;
  localparam int ACC_W  = SAMPLE_BITS + COEF_W + 3;
  localparam int Y_W    = ACC_W - FRAC;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration
  logic signed [COEF_W-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  logic [iir_df1_pkg::USED_W-1:0] used_b_q, used_a_q;
  iir_df1_pkg::cfg_reg_e reg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = iir_df1_pkg::cfg_reg_e'(paddr[iir_df1_pkg::APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= iir_df1_pkg::COEF_B0_RESET;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
      used_b_q  <= iir_df1_pkg::USED_RESET;
      used_a_q  <= iir_df1_pkg::USED_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        iir_df1_pkg::REG_COEF_B0: coef_b0_q <= pwdata[COEF_W-1:0];
        iir_df1_pkg::REG_COEF_B1: coef_b1_q <= pwdata[COEF_W-1:0];
        iir_df1_pkg::REG_COEF_B2: coef_b2_q <= pwdata[COEF_W-1:0];
        iir_df1_pkg::REG_COEF_A1: coef_a1_q <= pwdata[COEF_W-1:0];
        iir_df1_pkg::REG_COEF_A2: coef_a2_q <= pwdata[COEF_W-1:0];
        iir_df1_pkg::REG_USED_B:  used_b_q  <= pwdata[iir_df1_pkg::USED_W-1:0];
        iir_df1_pkg::REG_USED_A:  used_a_q  <= pwdata[iir_df1_pkg::USED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      iir_df1_pkg::REG_COEF_B0: prdata = iir_df1_pkg::APB_DATA_W'(coef_b0_q);
      iir_df1_pkg::REG_COEF_B1: prdata = iir_df1_pkg::APB_DATA_W'(coef_b1_q);
      iir_df1_pkg::REG_COEF_B2: prdata = iir_df1_pkg::APB_DATA_W'(coef_b2_q);
      iir_df1_pkg::REG_COEF_A1: prdata = iir_df1_pkg::APB_DATA_W'(coef_a1_q);
      iir_df1_pkg::REG_COEF_A2: prdata = iir_df1_pkg::APB_DATA_W'(coef_a2_q);
      iir_df1_pkg::REG_USED_B:  prdata = iir_df1_pkg::APB_DATA_W'(used_b_q);
      iir_df1_pkg::REG_USED_A:  prdata = iir_df1_pkg::APB_DATA_W'(used_a_q);
      default:                  prdata = '0;
    endcase
  end

  // input register and handshake
  logic                           in_valid_q;
  logic signed [SAMPLE_BITS-1:0]  sample_q;
  logic                           out_valid_q;
  logic [SAMPLE_BITS-1:0]         out_filtered_q;
  logic                           out_clip_q;
  logic                           step;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  // histories and warm-up
  logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
  logic [iir_df1_pkg::USED_W-1:0] warm_q, warm_d;

  // multiply-accumulate
  logic signed [ACC_W-1:0] prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
  logic signed [ACC_W-1:0] acc, rounded;
  logic signed [Y_W-1:0]   y_full;
  logic [Y_W-SAMPLE_BITS:0] y_upper;
  logic                    use_b1, use_b2, use_a1, use_a2, ovf;
  logic [iir_df1_pkg::USED_W-1:0] nb;
  logic [SAMPLE_BITS-1:0]  y_sat, shown;

  assign prod_b0 = coef_b0_q * sample_q;
  assign prod_b1 = coef_b1_q * x1_q;
  assign prod_b2 = coef_b2_q * x2_q;
  assign prod_a1 = coef_a1_q * y1_q;
  assign prod_a2 = coef_a2_q * y2_q;

  assign use_b1 = used_b_q[1];
  assign use_b2 = (used_b_q == iir_df1_pkg::USED_MAX);
  assign use_a1 = used_a_q[1];
  assign use_a2 = (used_a_q == iir_df1_pkg::USED_MAX);

  assign acc = prod_b0
             + (use_b1 ? prod_b1 : '0)
             + (use_b2 ? prod_b2 : '0)
             - (use_a1 ? prod_a1 : '0)
             - (use_a2 ? prod_a2 : '0);

  assign rounded = acc + ROUND_HALF;
  assign y_full  = rounded[ACC_W-1:FRAC];
  assign y_upper = y_full[Y_W-1:SAMPLE_BITS-1];
  assign ovf     = !((&y_upper) || !(|y_upper));

  always_comb begin
    if (!ovf) begin
      y_sat = y_full[SAMPLE_BITS-1:0];
    end else if (y_full[Y_W-1]) begin
      y_sat = SAT_LO;
    end else begin
      y_sat = SAT_HI;
    end
  end

  assign warm_d = (warm_q == iir_df1_pkg::WARMUP_MAX) ? warm_q
                                                       : warm_q + iir_df1_pkg::USED_W'(1);
  assign nb     = (used_b_q == '0) ? iir_df1_pkg::USED_W'(1) : used_b_q;
  assign shown  = (warm_d < nb) ? '0 : y_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q   <= '0;
      x2_q   <= '0;
      y1_q   <= '0;
      y2_q   <= '0;
      warm_q <= iir_df1_pkg::WARMUP_RESET;
    end else if (step) begin
      x1_q   <= sample_q;
      x2_q   <= x1_q;
      y1_q   <= y_sat;
      y2_q   <= y1_q;
      warm_q <= warm_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_filtered_q <= shown;
      out_clip_q     <= ovf;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = DATA_W'(out_filtered_q);
  assign m_axis_tuser[0] = out_clip_q;

endmodule

// ----- sv/iir_df1_chk.sv -----
`timescale 1ns / 1ps
// iir_df1_chk: port-level checks for iir_direct_form_one_filter, with bind.
// No package dependency.
module iir_df1_chk #(
  parameter int SAMPLE_BITS = 16,
  localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [0:0]        m_axis_tuser
);

  localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-1:0] filtered;
  assign filtered = m_axis_tdata[SAMPLE_BITS-1:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output payload changed");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (filtered == SAT_HI) || (filtered == SAT_LO) || (filtered == '0))
    else $error("clipped result not at a saturation limit");

endmodule

bind iir_direct_form_one_filter iir_df1_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_iir_df1_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/iir_direct_form_one_filter_test.sv -----
`timescale 1ns / 1ps
// iir_direct_form_one_filter_test: self-checking bench for the direct form I IIR filter.
// A table of directed samples and register writes runs first, then randomized phases.
// Depends on iir_df1_pkg and iir_direct_form_one_filter.
module iir_direct_form_one_filter_test;

  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = iir_df1_pkg::COEF_W;
  localparam int COEF_FRAC_BITS = iir_df1_pkg::COEF_FRAC_BITS;
  localparam int USED_W         = iir_df1_pkg::USED_W;
  localparam int REG_IDX_W      = iir_df1_pkg::REG_IDX_W;
  localparam int APB_ADDR_W     = iir_df1_pkg::APB_ADDR_W;
  localparam int APB_DATA_W     = iir_df1_pkg::APB_DATA_W;
  localparam int RANDOM_ITEMS   = 600;
  localparam int IDLE_LIMIT     = 1000;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [REG_IDX_W-1:0] REG_OUT_OF_RANGE = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [REG_IDX_W-1:0] reg_idx;
    int                   value;
    bit                   typed;
    int                   want_filtered;
    bit                   want_clipped;
  } stim_row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } filter_out_t;

  localparam int N_DIRECTED = 40;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // warm-up with three taps; first output forced to zero but still flagged clipped
    '{ROW_WRITE,  iir_df1_pkg::REG_USED_B,  3,       0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_B0, 131071,  0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 32767,   1, 0,      1},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, -32768,  1, -32768, 1},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 0,       1, 0,      0},
    // unity gain, write to an unmapped register must not land
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_B0, 16384,   0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_USED_B,  1,       0, 0,      0},
    '{ROW_WRITE,  REG_OUT_OF_RANGE,         131071,  0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 32767,   1, 32767,  0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, -32768,  1, -32768, 0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 1,       1, 1,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, -1,      1, -1,     0},
    // all taps at extremes
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_B0, -131072, 0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_B1, 131071,  0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_B2, -131072, 0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_A1, 131071,  0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_A2, -131072, 0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_USED_B,  3,       0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_USED_A,  3,       0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 32767,   0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, -32768,  0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 32767,   0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 0,       0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, -1,      0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 1,       0, 0,      0},
    // zero tap counts behave as one tap
    '{ROW_WRITE,  iir_df1_pkg::REG_USED_B,  0,       0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_USED_A,  0,       0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_B0, -16384,  0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, -32768,  1, 32767,  1},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 32767,   1, -32767, 0},
    // two taps each, half-up rounding
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_B0, 8192,    0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_B1, 8192,    0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_COEF_A1, -8192,   0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_USED_B,  2,       0, 0,      0},
    '{ROW_WRITE,  iir_df1_pkg::REG_USED_A,  2,       0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 1,       0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, -1,      0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 16383,   0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, -16384,  0, 0,      0},
    '{ROW_SAMPLE, iir_df1_pkg::REG_COEF_B0, 1234,    0, 0,      0}
  };

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  s_axis_tvalid  = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata   = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready  = 1'b0;
  logic [SAMPLE_W-1:0]   m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // filter model state
  logic signed [COEF_W-1:0]   coef_ff [3] = '{iir_df1_pkg::COEF_B0_RESET, '0, '0};
  logic signed [COEF_W-1:0]   coef_fb [3] = '{'0, '0, '0};
  logic [USED_W-1:0]          ff_taps     = iir_df1_pkg::USED_RESET;
  logic [USED_W-1:0]          fb_taps     = iir_df1_pkg::USED_RESET;
  logic signed [SAMPLE_W-1:0] x_hist [2]  = '{'0, '0};
  logic signed [SAMPLE_W-1:0] y_hist [2]  = '{'0, '0};
  int                         warmup      = int'(iir_df1_pkg::WARMUP_RESET);

  filter_out_t pending_outputs [$];
  int          mismatches  = 0;
  int          burst_left  = 0;
  bit          streaming   = 0;
  bit          apb_active  = 0;
  int          idle_cycles = 0;
  int          rx_cycle    = 0;
  int          rx_mode     = 0;

  iir_direct_form_one_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // sample
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // filtered
    .m_axis_tuser  (m_axis_tuser),   // clipped
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic filter_out_t filter_next(input logic signed [SAMPLE_W-1:0] x);
    int          nb;
    int          na;
    longint      acc;
    longint      y;
    filter_out_t r;
    nb  = (ff_taps == 0) ? 1 : int'(ff_taps);
    na  = (fb_taps == 0) ? 1 : int'(fb_taps);
    acc = longint'(coef_ff[0]) * longint'(x);
    if (nb > 1) acc += longint'(coef_ff[1]) * longint'(x_hist[0]);
    if (nb > 2) acc += longint'(coef_ff[2]) * longint'(x_hist[1]);
    if (na > 1) acc -= longint'(coef_fb[1]) * longint'(y_hist[0]);
    if (na > 2) acc -= longint'(coef_fb[2]) * longint'(y_hist[1]);
    y = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    r.clipped = 1'b0;
    if (y > 32767) begin
      y = 32767;
      r.clipped = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      r.clipped = 1'b1;
    end
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    y_hist[1] = y_hist[0];
    y_hist[0] = SAMPLE_W'(y);
    if (warmup < int'(iir_df1_pkg::WARMUP_MAX)) warmup++;
    r.filtered = (warmup < nb) ? '0 : SAMPLE_W'(y);
    return r;
  endfunction

  function automatic void track_write(input logic [REG_IDX_W-1:0] idx, input int value);
    case (idx)
      iir_df1_pkg::REG_COEF_B0: coef_ff[0] = value[COEF_W-1:0];
      iir_df1_pkg::REG_COEF_B1: coef_ff[1] = value[COEF_W-1:0];
      iir_df1_pkg::REG_COEF_B2: coef_ff[2] = value[COEF_W-1:0];
      iir_df1_pkg::REG_COEF_A1: coef_fb[1] = value[COEF_W-1:0];
      iir_df1_pkg::REG_COEF_A2: coef_fb[2] = value[COEF_W-1:0];
      iir_df1_pkg::REG_USED_B:  ff_taps    = value[USED_W-1:0];
      iir_df1_pkg::REG_USED_A:  fb_taps    = value[USED_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int rand_coef();
    case ($urandom_range(0, 5))
      0:       return -131072;
      1:       return 131071;
      2, 3:    return int'($urandom_range(0, 32768)) - 16384;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // lower valid and wait until every sent sample has come back
  task automatic settle();
    if (streaming) begin
      s_axis_tvalid <= 1'b0;
      streaming = 0;
    end
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    apb_active = 1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    track_write(idx, value);
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] x, input bit typed,
                             input filter_out_t want);
    int          gap;
    filter_out_t predicted;
    if (apb_active) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      apb_active = 0;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        if (streaming) s_axis_tvalid <= 1'b0;
        streaming = 0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    streaming = 1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = filter_next(x);
    pending_outputs.push_back(typed ? want : predicted);
    burst_left--;
  endtask

  task automatic note_mismatch(input filter_out_t want, input filter_out_t got,
                               input bit unexpected);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      if (unexpected)
        $display("mismatch %0d: output transaction with none pending, filtered=%0d clipped=%0d",
                 mismatches, got.filtered, got.clipped);
      else
        $display("mismatch %0d: expected filtered=%0d clipped=%0d, got filtered=%0d clipped=%0d",
                 mismatches, want.filtered, want.clipped, got.filtered, got.clipped);
    end
  endtask

  // receiver stall pattern, one of four modes chosen at random
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= $urandom_range(0, 1) == 1;
      2:       m_axis_tready <= $urandom_range(0, 3) == 0;
      default: m_axis_tready <= $urandom_range(0, 3) != 0;
    endcase
  end

  always @(posedge clk_i) begin
    filter_out_t want;
    filter_out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.filtered = m_axis_tdata;
      got.clipped  = m_axis_tuser[0];
      if (pending_outputs.size() == 0) begin
        want = got;
        note_mismatch(want, got, 1'b1);
      end else begin
        want = pending_outputs.pop_front();
        if (got.filtered !== want.filtered || got.clipped !== want.clipped)
          note_mismatch(want, got, 1'b0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    filter_out_t want;
    int          sent;
    int          n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle();
        cfg_write(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        want.filtered = SAMPLE_W'(directed_rows[i].want_filtered);
        want.clipped  = directed_rows[i].want_clipped;
        push_sample(directed_rows[i].value[SAMPLE_W-1:0], directed_rows[i].typed, want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 3) != 0) cfg_write(iir_df1_pkg::REG_COEF_B0, rand_coef());
      if ($urandom_range(0, 3) != 0) cfg_write(iir_df1_pkg::REG_COEF_B1, rand_coef());
      if ($urandom_range(0, 3) != 0) cfg_write(iir_df1_pkg::REG_COEF_B2, rand_coef());
      if ($urandom_range(0, 3) != 0) cfg_write(iir_df1_pkg::REG_COEF_A1, rand_coef());
      if ($urandom_range(0, 3) != 0) cfg_write(iir_df1_pkg::REG_COEF_A2, rand_coef());
      if ($urandom_range(0, 2) != 0) cfg_write(iir_df1_pkg::REG_USED_B, $urandom_range(0, 3));
      if ($urandom_range(0, 2) != 0) cfg_write(iir_df1_pkg::REG_USED_A, $urandom_range(0, 3));
      n = $urandom_range(10, 60);
      repeat (n) push_sample(rand_sample(), 1'b0, want);
      sent += n;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- iir_direct_form_one_filter.f -----
sv/iir_df1_pkg.sv
sv/iir_direct_form_one_filter.sv
sv/iir_df1_chk.sv
tb/iir_direct_form_one_filter_test.sv
